// ----- rtl/core/dtus_pkg.sv -----
// Shared types and constants for the date text to Unix seconds converter.
// Used by the front parser, the record queue, the date back end and the top level.
// No dependencies.
`timescale 1ns / 1ps

package dtus_pkg;

    // Part of the date text being parsed
    typedef enum logic [1:0] {
        PART_MONTH,
        PART_DAY,
        PART_YEAR
    } t_part;

    // Kind of leading quote that was stripped
    typedef enum logic [1:0] {
        QUOTE_NONE,
        QUOTE_DOUBLE,
        QUOTE_SINGLE
    } t_quote;

    // Integer conversion phase of the current part
    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGN,
        PH_DIGITS,
        PH_STOP
    } t_phase;

    // Back end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_ADJ,
        B_DIV,
        B_YOE,
        B_DOE,
        B_DAYS,
        B_SEC,
        B_OUT
    } t_bstate;

    // One parsed text, handed from the front to the back
    typedef struct packed {
        logic        ok;
        logic [31:0] month;
        logic [31:0] day;
        logic [31:0] year;
    } t_rec;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Back end status
    typedef struct packed {
        logic idle;
    } t_back_stat;

    // Characters
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Magnitude saturation point of the integer conversion (2^31)
    localparam logic [34:0] MAG_LIMIT = 35'd2147483648;

    // Calendar arithmetic
    localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
    localparam logic [17:0] DAYS_PER_ERA   = 18'd146097;
    localparam logic [19:0] EPOCH_OFFSET   = 20'd719468;
    localparam logic [8:0]  YEARS_PER_ERA  = 9'd400;
    localparam logic [7:0]  MONTH_MUL      = 8'd153;
    localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;

    // Exact division by 25 of a value below 2^30: (u * RECIP25) >> 35
    localparam logic [30:0] RECIP25        = 31'd1374389535;
    // Bias that keeps the quotient input positive: 25 * 2^24
    localparam logic [29:0] DIV25_BIAS     = 30'd419430400;
    localparam logic [25:0] DIV25_OFFSET   = 26'd16777216;
    // Exact unsigned 32-bit division by 5: (x * RECIP5) >> 34
    localparam logic [31:0] RECIP5         = 32'hCCCCCCCD;

endpackage

// ----- rtl/core/dtus_front.sv -----
// Front parser: takes one character a cycle unless the queue is full, trims,
// strips quotes, splits and converts the three parts, pushes one record per text. Uses dtus_pkg.
`timescale 1ns / 1ps

module dtus_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_ch,
    input  logic               i_last,
    output logic               o_ready,
    input  dtus_pkg::t_q_stat  i_q_stat,
    output logic               o_push,
    output dtus_pkg::t_rec     o_rec
);

    typedef struct packed {
        logic        ok;
        logic [31:0] val;
    } t_fin;

    // Whitespace test: space, TAB, LF, VT, FF, CR
    function automatic logic is_ws(input logic [7:0] c);
        return (c == dtus_pkg::CH_SPACE) ||
               (c >= dtus_pkg::CH_TAB && c <= dtus_pkg::CH_CR);
    endfunction

    // Check a finished part and give its 32-bit pattern
    function automatic t_fin finish_num(
        input logic              failed,
        input dtus_pkg::t_phase  ph,
        input logic              ovf,
        input logic              neg,
        input logic [31:0]       mag
    );
        t_fin f;
        f.ok  = !failed && !ovf &&
                (ph == dtus_pkg::PH_DIGITS || ph == dtus_pkg::PH_STOP);
        f.val = neg ? (32'd0 - mag) : mag;
        // positive values stop at 2^31 - 1
        if (!neg && mag[31]) begin
            f.ok = 1'b0;
        end
        return f;
    endfunction

    dtus_pkg::t_part  r_part, n_part;
    logic             r_seen, n_seen;
    dtus_pkg::t_quote r_quote, n_quote;
    logic [7:0]       r_last_ns, n_last_ns;
    dtus_pkg::t_phase r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [31:0]      r_mag, n_mag;
    logic             r_ovf, n_ovf;
    logic             r_failed, n_failed;
    logic [31:0]      r_month, n_month;
    logic [31:0]      r_day, n_day;
    logic [1:0]       r_parts_ok, n_parts_ok;

    logic             w_accept;
    logic             w_ws;
    logic             w_digit;
    logic             w_consumed;
    logic [34:0]      w_v;
    t_fin             w_fin_slash;
    t_fin             w_fin_end;

    assign o_ready  = !i_q_stat.full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && i_last;

    // Next parse state for the current character, and the record it would close
    always_comb begin
        n_part      = r_part;
        n_seen      = r_seen;
        n_quote     = r_quote;
        n_last_ns   = r_last_ns;
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_ovf       = r_ovf;
        n_failed    = r_failed;
        n_month     = r_month;
        n_day       = r_day;
        n_parts_ok  = r_parts_ok;
        w_consumed  = 1'b0;

        w_ws        = is_ws(i_ch);
        w_digit     = (i_ch >= dtus_pkg::CH_ZERO) && (i_ch <= dtus_pkg::CH_NINE);
        w_v         = {3'd0, r_mag} * 35'd10 + {31'd0, i_ch[3:0]};
        w_fin_slash = finish_num(r_failed, r_phase, r_ovf, r_neg, r_mag);

        // Track the first and last non-space characters; strip a leading quote
        if (!w_ws) begin
            if (!r_seen) begin
                n_seen = 1'b1;
                if (i_ch == dtus_pkg::CH_DQUOTE) begin
                    n_quote    = dtus_pkg::QUOTE_DOUBLE;
                    w_consumed = 1'b1;
                end else if (i_ch == dtus_pkg::CH_SQUOTE) begin
                    n_quote    = dtus_pkg::QUOTE_SINGLE;
                    w_consumed = 1'b1;
                end
            end
            n_last_ns = i_ch;
        end

        if (!w_consumed) begin
            if (r_part != dtus_pkg::PART_YEAR && i_ch == dtus_pkg::CH_SLASH) begin
                // Close the month or day part and start the next
                if (w_fin_slash.ok) begin
                    if (r_part == dtus_pkg::PART_MONTH) begin
                        n_month = w_fin_slash.val;
                    end else begin
                        n_day = w_fin_slash.val;
                    end
                    n_parts_ok = r_parts_ok + 2'd1;
                end
                n_part   = (r_part == dtus_pkg::PART_MONTH) ? dtus_pkg::PART_DAY
                                                            : dtus_pkg::PART_YEAR;
                n_phase  = dtus_pkg::PH_SKIP;
                n_neg    = 1'b0;
                n_mag    = 32'd0;
                n_ovf    = 1'b0;
                n_failed = 1'b0;
            end else if (!r_failed) begin
                // Advance the integer conversion
                unique case (r_phase)
                    dtus_pkg::PH_SKIP: begin
                        if (w_ws) begin
                            n_phase = dtus_pkg::PH_SKIP;
                        end else if (i_ch == dtus_pkg::CH_PLUS ||
                                     i_ch == dtus_pkg::CH_MINUS) begin
                            n_neg   = (i_ch == dtus_pkg::CH_MINUS);
                            n_phase = dtus_pkg::PH_SIGN;
                        end else if (w_digit) begin
                            n_phase = dtus_pkg::PH_DIGITS;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    dtus_pkg::PH_SIGN: begin
                        if (w_digit) begin
                            n_phase = dtus_pkg::PH_DIGITS;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    dtus_pkg::PH_DIGITS: begin
                        if (!w_digit) begin
                            n_phase = dtus_pkg::PH_STOP;
                        end
                    end
                    dtus_pkg::PH_STOP: begin
                        n_phase = dtus_pkg::PH_STOP;
                    end
                endcase
                // Take the digit, saturating at 2^31
                if (w_digit && r_phase != dtus_pkg::PH_STOP) begin
                    if (w_v > dtus_pkg::MAG_LIMIT) begin
                        n_ovf = 1'b1;
                        n_mag = 32'h8000_0000;
                    end else begin
                        n_mag = w_v[31:0];
                    end
                end
            end
        end

        // Record closed by a final character
        w_fin_end    = finish_num(n_failed, n_phase, n_ovf, n_neg, n_mag);
        o_rec.ok     = w_fin_end.ok &&
                       (n_part == dtus_pkg::PART_YEAR) && (n_parts_ok == 2'd2) &&
                       !(n_quote == dtus_pkg::QUOTE_DOUBLE &&
                         n_last_ns != dtus_pkg::CH_DQUOTE) &&
                       !(n_quote == dtus_pkg::QUOTE_SINGLE &&
                         n_last_ns != dtus_pkg::CH_SQUOTE);
        o_rec.month  = n_month;
        o_rec.day    = n_day;
        o_rec.year   = w_fin_end.val;
    end

    // Parse state: advance on each request, clear after the final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_last)) begin
            r_part     <= dtus_pkg::PART_MONTH;
            r_seen     <= 1'b0;
            r_quote    <= dtus_pkg::QUOTE_NONE;
            r_last_ns  <= 8'd0;
            r_phase    <= dtus_pkg::PH_SKIP;
            r_neg      <= 1'b0;
            r_mag      <= 32'd0;
            r_ovf      <= 1'b0;
            r_failed   <= 1'b0;
            r_month    <= 32'd0;
            r_day      <= 32'd0;
            r_parts_ok <= 2'd0;
        end else if (w_accept) begin
            r_part     <= n_part;
            r_seen     <= n_seen;
            r_quote    <= n_quote;
            r_last_ns  <= n_last_ns;
            r_phase    <= n_phase;
            r_neg      <= n_neg;
            r_mag      <= n_mag;
            r_ovf      <= n_ovf;
            r_failed   <= n_failed;
            r_month    <= n_month;
            r_day      <= n_day;
            r_parts_ok <= n_parts_ok;
        end
    end

endmodule

// ----- rtl/core/dtus_queue.sv -----
// Short queue of parsed records between the front parser and the back end.
// Uses dtus_pkg for the record and status types.
`timescale 1ns / 1ps

module dtus_queue #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  dtus_pkg::t_rec     i_rec,
    input  logic               i_pop,
    output dtus_pkg::t_rec     o_rec,
    output dtus_pkg::t_q_stat  o_stat
);

    // DEPTH of two or more
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    dtus_pkg::t_rec r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_count;

    assign o_rec        = r_mem[r_rd];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Store a pushed record
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                2'b00,
                2'b11:   r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/core/dtus_back.sv -----
// Back end: turns a parsed month, day and year into Unix seconds over a short
// sequence of register steps and holds the result. Uses dtus_pkg.
`timescale 1ns / 1ps

module dtus_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dtus_pkg::t_q_stat     i_q_stat,
    input  dtus_pkg::t_rec        i_rec,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_ok,
    output logic [56:0]           o_secs,
    output dtus_pkg::t_back_stat  o_stat
);

    dtus_pkg::t_bstate r_state, n_state;

    dtus_pkg::t_rec    r_rec;
    logic [32:0]       r_y;
    logic [29:0]       r_u;
    logic [31:0]       r_prod5;
    logic [25:0]       r_era;
    logic [31:0]       r_q5;
    logic [8:0]        r_yoe;
    logic [31:0]       r_doy;
    logic [43:0]       r_eday;
    logic [31:0]       r_doe;
    logic [44:0]       r_days;
    logic              r_ok;
    logic [56:0]       r_secs;

    logic              w_mle2;
    logic [32:0]       w_y;
    logic [29:0]       w_u;
    logic [31:0]       w_shift;
    logic [31:0]       w_prod5;
    logic [60:0]       w_p25;
    logic [25:0]       w_era;
    logic [63:0]       w_p5;
    logic [32:0]       w_era400;
    logic [8:0]        w_yoe;
    logic [31:0]       w_doy;
    logic [43:0]       w_eday;
    logic [1:0]        w_cent;
    logic [31:0]       w_doe;
    logic [44:0]       w_days;
    logic [56:0]       w_secs;

    // Sequence one record through the arithmetic steps
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            dtus_pkg::B_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_state = dtus_pkg::B_ADJ;
                end
            end
            dtus_pkg::B_ADJ:  n_state = dtus_pkg::B_DIV;
            dtus_pkg::B_DIV:  n_state = dtus_pkg::B_YOE;
            dtus_pkg::B_YOE:  n_state = dtus_pkg::B_DOE;
            dtus_pkg::B_DOE:  n_state = dtus_pkg::B_DAYS;
            dtus_pkg::B_DAYS: n_state = dtus_pkg::B_SEC;
            dtus_pkg::B_SEC:  n_state = dtus_pkg::B_OUT;
            dtus_pkg::B_OUT: begin
                if (i_ready) begin
                    n_state = dtus_pkg::B_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtus_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Year shift into a March-based year, biased for the division by 400
    assign w_mle2  = (r_rec.month <= 32'd2);
    assign w_y     = {r_rec.year[31], r_rec.year} - {32'd0, w_mle2};
    assign w_u     = {w_y[32], w_y[32:4]} + dtus_pkg::DIV25_BIAS;
    assign w_shift = (r_rec.month > 32'd2) ? (r_rec.month - 32'd3)
                                           : (r_rec.month + 32'd9);
    assign w_prod5 = w_shift * {24'd0, dtus_pkg::MONTH_MUL} + 32'd2;

    // Era by reciprocal of 25, day of year by reciprocal of 5
    assign w_p25   = {31'd0, r_u} * {30'd0, dtus_pkg::RECIP25};
    assign w_era   = w_p25[60:35] - dtus_pkg::DIV25_OFFSET;
    assign w_p5    = {32'd0, r_prod5} * {32'd0, dtus_pkg::RECIP5};

    // Year of era, day of year and era days
    assign w_era400 = {{7{r_era[25]}}, r_era} * {24'd0, dtus_pkg::YEARS_PER_ERA};
    assign w_yoe    = r_y[8:0] - w_era400[8:0];
    assign w_doy    = r_q5 + r_rec.day - 32'd1;
    assign w_eday   = {{18{r_era[25]}}, r_era} * {26'd0, dtus_pkg::DAYS_PER_ERA};

    // Day of era; centuries within the era by compare
    assign w_cent = (r_yoe >= 9'd300) ? 2'd3 :
                    (r_yoe >= 9'd200) ? 2'd2 :
                    (r_yoe >= 9'd100) ? 2'd1 : 2'd0;
    assign w_doe  = {23'd0, r_yoe} * {23'd0, dtus_pkg::DAYS_PER_YEAR}
                  + {25'd0, r_yoe[8:2]} - {30'd0, w_cent} + r_doy;

    // Days since the epoch, then seconds
    assign w_days = {r_eday[43], r_eday} + {13'd0, r_doe}
                  - {25'd0, dtus_pkg::EPOCH_OFFSET};
    assign w_secs = {{12{r_days[44]}}, r_days} * {40'd0, dtus_pkg::SECS_PER_DAY};

    // Step registers, loaded in their own state
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
        if (r_state == dtus_pkg::B_ADJ) begin
            r_y     <= w_y;
            r_u     <= w_u;
            r_prod5 <= w_prod5;
        end
        if (r_state == dtus_pkg::B_DIV) begin
            r_era <= w_era;
            r_q5  <= {2'd0, w_p5[63:34]};
        end
        if (r_state == dtus_pkg::B_YOE) begin
            r_yoe  <= w_yoe;
            r_doy  <= w_doy;
            r_eday <= w_eday;
        end
        if (r_state == dtus_pkg::B_DOE) begin
            r_doe <= w_doe;
        end
        if (r_state == dtus_pkg::B_DAYS) begin
            r_days <= w_days;
        end
        if (r_state == dtus_pkg::B_SEC) begin
            r_ok   <= r_rec.ok;
            r_secs <= r_rec.ok ? w_secs : 57'd0;
        end
    end

    assign o_valid     = (r_state == dtus_pkg::B_OUT);
    assign o_ok        = r_ok;
    assign o_secs      = r_secs;
    assign o_stat.idle = (r_state == dtus_pkg::B_IDLE);

endmodule

// ----- rtl/core/date_text_to_unix_seconds.sv -----
// Date text to Unix seconds converter, top level.
//
// Slave channel: one character of an MM/DD/YYYY text per request in
// i_s_tdata, i_s_tlast high on the final character. Surrounding
// whitespace and one matching pair of quotes are dropped; each part is
// read as a signed 32-bit decimal integer.
// Master channel: one request per text. o_m_tuser is 1 when the text was
// a date; o_m_tdata then holds seconds since 1970-01-01 (57-bit two's
// complement), and zero otherwise.
// Result path: when the back end is free, it takes the record from the queue,
// steps through its arithmetic states and then raises o_m_tvalid.
// Throughput: one character per cycle while the queue has room; the back
// end sequencer handles one text at a time (one take, six arithmetic steps
// and one output state), and a queue of QUEUE_DEPTH parsed texts absorbs
// short texts.
// Receiver stall: the result holds in its output register; the parser
// keeps taking characters until the queue is full, then drops o_s_tready.
// Reset (i_rst_n low, synchronous) clears parse state, the queue and
// the sequencer; there is no clearing pass.
// Uses dtus_pkg, dtus_front, dtus_queue and dtus_back.
`timescale 1ns / 1ps

module date_text_to_unix_seconds #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic        i_s_tlast,   // last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [56:0] unix_seconds, [63:57] zero
    output logic        o_m_tuser    // [0] valid_res
);

    dtus_pkg::t_q_stat    w_q_stat;
    dtus_pkg::t_back_stat w_back_stat;
    dtus_pkg::t_rec       w_push_rec;
    dtus_pkg::t_rec       w_pop_rec;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_ok;
    logic [56:0]          w_secs;

    dtus_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_ch     (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_ready  (o_s_tready),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_rec    (w_push_rec)
    );

    dtus_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .i_pop   (w_pop),
        .o_rec   (w_pop_rec),
        .o_stat  (w_q_stat)
    );

    dtus_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_rec    (w_pop_rec),
        .o_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_ok     (w_ok),
        .o_secs   (w_secs),
        .o_stat   (w_back_stat)
    );

    assign o_m_tdata = {7'd0, w_secs};
    assign o_m_tuser = w_ok;

`ifndef SYNTHESIS
    // The back end only takes records that are there
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("record taken from empty queue");

    // A text reaching an idle back end is answered after a fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_q_stat.empty && w_back_stat.idle) |-> ##8 o_m_tvalid)
        else $error("result not offered on time");

    // A rejected text carries zero seconds
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 64'd0))
        else $error("invalid result with nonzero seconds");
`endif

endmodule

// ----- tb/dtus_date_checker.sv -----
`timescale 1ns / 1ps
// Result checker for date_text_to_unix_seconds: follows every accepted character,
// predicts the date result of each text and compares it with the master channel.
// Depends on dtus_pkg for the parse enums and the character codes.

module dtus_date_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic        i_s_tlast,   // last
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,   // [56:0] unix_seconds, [63:57] zero
    input  logic        i_m_tuser,   // [0] valid_res
    output int          o_fail_count,
    output int          o_pending,
    output int          o_compared,
    output int          o_dates
);

    typedef struct packed {
        logic        is_date;
        logic [56:0] secs;
    } t_date_result;

    t_date_result expected_dates[$];

    // Parse state of the text in flight
    dtus_pkg::t_part  part_sel;
    logic             seen_text;
    dtus_pkg::t_quote open_quote;
    logic [7:0]       last_text_char;
    dtus_pkg::t_phase num_phase;
    logic             num_neg;
    logic [31:0]      num_mag;
    logic             num_ovf;
    logic             num_bad;
    logic [31:0]      month_bits;
    logic [31:0]      day_bits;
    int unsigned      parts_done;

    int fail_total;
    int compare_total;
    int date_total;

    function automatic logic is_space(logic [7:0] c);
        return c == dtus_pkg::CH_SPACE ||
               (c >= dtus_pkg::CH_TAB && c <= dtus_pkg::CH_CR);
    endfunction

    function automatic void clear_number();
        num_phase = dtus_pkg::PH_SKIP;
        num_neg   = 1'b0;
        num_mag   = '0;
        num_ovf   = 1'b0;
        num_bad   = 1'b0;
    endfunction

    function automatic void clear_text();
        part_sel       = dtus_pkg::PART_MONTH;
        seen_text      = 1'b0;
        open_quote     = dtus_pkg::QUOTE_NONE;
        last_text_char = '0;
        clear_number();
        month_bits     = '0;
        day_bits       = '0;
        parts_done     = 0;
    endfunction

    // Accumulate one decimal digit, saturating at 2^31
    function automatic void take_digit(logic [7:0] c);
        logic [35:0] acc;
        logic [7:0]  digit;
        digit = c - dtus_pkg::CH_ZERO;
        acc = {4'b0, num_mag} * 36'd10 + {28'b0, digit};
        if (acc > {1'b0, dtus_pkg::MAG_LIMIT}) begin
            num_ovf = 1'b1;
            acc = {1'b0, dtus_pkg::MAG_LIMIT};
        end
        num_mag = acc[31:0];
    endfunction

    // Integer conversion of one part: whitespace, sign, digits, then stop
    function automatic void feed_number(logic [7:0] c);
        logic digit;
        digit = c >= dtus_pkg::CH_ZERO && c <= dtus_pkg::CH_NINE;
        if (num_bad || num_phase == dtus_pkg::PH_STOP)
            return;
        case (num_phase)
            dtus_pkg::PH_SKIP: begin
                if (is_space(c))
                    return;
                if (c == dtus_pkg::CH_PLUS || c == dtus_pkg::CH_MINUS) begin
                    num_neg   = (c == dtus_pkg::CH_MINUS);
                    num_phase = dtus_pkg::PH_SIGN;
                end else if (digit) begin
                    take_digit(c);
                    num_phase = dtus_pkg::PH_DIGITS;
                end else begin
                    num_bad = 1'b1;
                end
            end
            dtus_pkg::PH_SIGN: begin
                if (digit) begin
                    take_digit(c);
                    num_phase = dtus_pkg::PH_DIGITS;
                end else begin
                    num_bad = 1'b1;
                end
            end
            default: begin
                if (digit)
                    take_digit(c);
                else
                    num_phase = dtus_pkg::PH_STOP;
            end
        endcase
    endfunction

    // Close the current part; 1 and its 32-bit pattern when it is in range
    function automatic logic finish_number(output logic [31:0] val);
        val = '0;
        if (num_bad || num_phase == dtus_pkg::PH_SKIP ||
            num_phase == dtus_pkg::PH_SIGN || num_ovf)
            return 1'b0;
        if (num_neg) begin
            val = 32'd0 - num_mag;
            return 1'b1;
        end
        if (num_mag > 32'h7FFF_FFFF)
            return 1'b0;
        val = num_mag;
        return 1'b1;
    endfunction

    // Day count from 1970-01-01; month, day, doy and doe wrap at 32 bits
    function automatic longint days_since_epoch(longint year, logic [31:0] m,
                                                logic [31:0] d);
        longint      y;
        longint      era;
        longint      rem;
        longint      doe_wide;
        logic [31:0] yoe;
        logic [31:0] shifted;
        logic [31:0] doy;
        logic [31:0] doe;
        y = (m <= 32'd2) ? year - 1 : year;
        era = (y >= 0 ? y : y - 399) / 400;
        rem = y - era * 400;
        yoe = rem[31:0];
        shifted = (m > 32'd2) ? m - 32'd3 : m + 32'd9;
        doy = (32'd153 * shifted + 32'd2) / 32'd5 + d - 32'd1;
        doe = yoe * 32'd365 + yoe / 32'd4 - yoe / 32'd100 + doy;
        doe_wide = {32'b0, doe};
        return era * 146097 + doe_wide - 719468;
    endfunction

    // Advance the parse by one character; on the final one queue the date
    function automatic void take_char(logic [7:0] c, logic fin);
        logic         quote_taken;
        logic [31:0]  part_bits;
        logic [31:0]  year_bits;
        logic         is_date;
        longint       year;
        longint       secs;
        t_date_result res;
        quote_taken = 1'b0;
        secs = 0;
        if (!is_space(c)) begin
            if (!seen_text) begin
                seen_text = 1'b1;
                if (c == dtus_pkg::CH_DQUOTE) begin
                    open_quote  = dtus_pkg::QUOTE_DOUBLE;
                    quote_taken = 1'b1;
                end else if (c == dtus_pkg::CH_SQUOTE) begin
                    open_quote  = dtus_pkg::QUOTE_SINGLE;
                    quote_taken = 1'b1;
                end
            end
            last_text_char = c;
        end
        if (!quote_taken) begin
            if (part_sel != dtus_pkg::PART_YEAR && c == dtus_pkg::CH_SLASH) begin
                if (finish_number(part_bits)) begin
                    if (part_sel == dtus_pkg::PART_MONTH)
                        month_bits = part_bits;
                    else
                        day_bits = part_bits;
                    parts_done++;
                end
                part_sel = (part_sel == dtus_pkg::PART_MONTH) ? dtus_pkg::PART_DAY
                                                              : dtus_pkg::PART_YEAR;
                clear_number();
            end else begin
                feed_number(c);
            end
        end
        if (fin) begin
            is_date = 1'b1;
            if (open_quote == dtus_pkg::QUOTE_DOUBLE && last_text_char != dtus_pkg::CH_DQUOTE)
                is_date = 1'b0;
            if (open_quote == dtus_pkg::QUOTE_SINGLE && last_text_char != dtus_pkg::CH_SQUOTE)
                is_date = 1'b0;
            if (part_sel != dtus_pkg::PART_YEAR || parts_done != 2)
                is_date = 1'b0;
            if (!finish_number(year_bits))
                is_date = 1'b0;
            if (is_date) begin
                year = $signed(year_bits);
                secs = days_since_epoch(year, month_bits, day_bits) * 86400;
            end
            res.is_date = is_date;
            res.secs    = is_date ? secs[56:0] : '0;
            expected_dates = {expected_dates, res};
            clear_text();
        end
    endfunction

    // Compare results first, then follow the slave channel
    always @(posedge i_clk) begin
        t_date_result want;
        if (!i_rst_n) begin
            clear_text();
            expected_dates.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_dates.size() == 0) begin
                    $error("result request with no date text pending: valid_res %0d",
                           i_m_tuser);
                    fail_total++;
                end else begin
                    want = expected_dates.pop_front();
                    compare_total++;
                    if (want.is_date)
                        date_total++;
                    if (i_m_tuser !== want.is_date) begin
                        $error("valid_res: expected %0d, got %0d", want.is_date, i_m_tuser);
                        fail_total++;
                    end
                    if (i_m_tdata[56:0] !== want.secs) begin
                        $error("unix_seconds: expected %0d, got %0d",
                               $signed(want.secs), $signed(i_m_tdata[56:0]));
                        fail_total++;
                    end
                    if (i_m_tdata[63:57] !== 7'd0) begin
                        $error("tdata padding: expected 0, got %0h", i_m_tdata[63:57]);
                        fail_total++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                take_char(i_s_tdata, i_s_tlast);
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_dates.size();
        o_compared   <= compare_total;
        o_dates      <= date_total;
    end

endmodule

// ----- tb/date_text_to_unix_seconds_test.sv -----
`timescale 1ns / 1ps
// Top of the date_text_to_unix_seconds testbench: clock, reset, date text stimulus
// in four idle/stall phases and the verdict. Depends on dtus_pkg and dtus_date_checker.

module date_text_to_unix_seconds_test;

    localparam int         CLK_HALF     = 6;
    localparam int         RESET_CYCLES = 6;
    localparam int         CHAR_BUDGET  = 1550;
    localparam int         PHASES       = 4;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         DRAIN_CYCLES = 24;
    localparam logic [7:0] NO_QUOTE     = 8'h00;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [63:0] m_tdata;
    logic        m_tuser;

    int fail_count;
    int pending;
    int compared;
    int dates;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int chars_sent     = 0;
    int texts_sent     = 0;
    int cycles         = 0;

    logic [7:0] text_buf[$];

    string limit_numbers [0:9] = '{
        "2147483647", "-2147483648", "2147483648", "-2147483649", "+0",
        "-0", "0000000000012", "99999999999999999999", "4294967295", "-1"
    };

    always #(CLK_HALF) clk = ~clk;

    date_text_to_unix_seconds i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    dtus_date_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_compared   (compared),
        .o_dates      (dates)
    );

    // Stall the receiver at the rate of the current phase
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Append one character to the text being built
    function automatic void append_char(logic [7:0] c);
        text_buf = {text_buf, c};
    endfunction

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
            append_char(s[i]);
    endfunction

    // Append n whitespace characters from space, TAB, LF, VT, FF and CR
    function automatic void push_ws(int n);
        int r;
        repeat (n) begin
            r = $urandom_range(5);
            append_char(r == 5 ? dtus_pkg::CH_SPACE : dtus_pkg::CH_TAB + 8'(r));
        end
    endfunction

    // Append one number part: mostly in the calendar range, else odd forms
    function automatic void push_number(int lo, int hi);
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            push_str($sformatf("%0d", $urandom_range(hi, lo)));
        end else if (r < 70) begin
            push_str(limit_numbers[$urandom_range(9)]);
        end else if (r < 78) begin
            push_str($sformatf("%0d", $signed($urandom())));
        end else if (r < 84) begin
            push_ws($urandom_range(1, 2));
            push_str($urandom_range(1) ? "+" : "-");
            push_str($sformatf("%0d", $urandom_range(hi, lo)));
        end else if (r < 90) begin
            case ($urandom_range(3))
                0: push_str("-");
                1: push_str("x1");
                2: push_str("+-1");
                default: ;
            endcase
        end else begin
            push_str($sformatf("%0d", $urandom_range(hi, lo)));
            append_char(8'($urandom_range(255)));
            push_str("7");
        end
    endfunction

    // Build an MM/DD/YYYY text with random content, optional quotes and padding
    function automatic void build_date(logic [7:0] quote);
        push_ws($urandom_range(2));
        if (quote != NO_QUOTE)
            append_char(quote);
        push_ws($urandom_range(1));
        push_number(1, 12);
        append_char(dtus_pkg::CH_SLASH);
        push_number(1, 31);
        append_char(dtus_pkg::CH_SLASH);
        push_number(1600, 2400);
        push_ws($urandom_range(1));
        if (quote != NO_QUOTE)
            append_char(quote);
        push_ws($urandom_range(2));
    endfunction

    // Pick a text: dates, broken dates, whitespace only, or plain noise
    function automatic void build_text();
        int         kind;
        int         idx;
        int         q;
        logic [7:0] quote;
        text_buf.delete();
        kind = $urandom_range(99);
        q = $urandom_range(9);
        quote = (q < 2) ? dtus_pkg::CH_DQUOTE : (q < 4) ? dtus_pkg::CH_SQUOTE : NO_QUOTE;
        if (kind < 84) begin
            build_date(quote);
            if (kind >= 62) begin
                idx = $urandom_range(text_buf.size() - 1);
                case ($urandom_range(3))
                    0: text_buf[idx] = 8'($urandom_range(255));
                    1: if (text_buf.size() > 1) text_buf.delete(idx);
                    2: text_buf.insert(idx, dtus_pkg::CH_SLASH);
                    default: begin
                        text_buf.push_front(dtus_pkg::CH_DQUOTE);
                        append_char(dtus_pkg::CH_SQUOTE);
                    end
                endcase
            end
        end else if (kind < 88) begin
            push_ws($urandom_range(1, 4));
        end else begin
            repeat ($urandom_range(1, 12))
                append_char($urandom_range(3) == 0 ? dtus_pkg::CH_SLASH
                                                   : 8'($urandom_range(255)));
        end
    endfunction

    // Offer the text one character per request, idling at the phase rate
    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++) begin
            while ($urandom_range(99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= text_buf[i];
            s_tlast  <= (i == text_buf.size() - 1);
            do @(posedge clk); while (!s_tready);
            chars_sent++;
        end
        texts_sent++;
    endtask

    initial begin
        int phase_idle  [0:PHASES-1];
        int phase_stall [0:PHASES-1];

        phase_idle  = '{0, 53, 0, 18};
        phase_stall = '{0, 0, 53, 18};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Epoch itself, then a quoted leap day in the most negative year
        text_buf.delete();
        push_str("1/1/1970");
        send_text();
        text_buf.delete();
        push_str("\t'2/29/-2147483648'\n");
        send_text();

        for (int p = 0; p < PHASES; p++) begin
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            while (chars_sent < (p + 1) * CHAR_BUDGET / PHASES) begin
                build_text();
                send_text();
            end
            // Hold the sender until every expected date has come back
            s_tvalid <= 1'b0;
            do @(posedge clk); while (pending != 0);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d characters in %0d texts across four idle/stall phases.",
                 chars_sent, texts_sent);
        $display("Compared %0d results, %0d of them valid dates.", compared, dates);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
